>>> hdl/brsoi_pkg.sv
package brsoi_pkg;

  // Block framing
  localparam int BLOCK_LEN = 100;
  localparam int POS_W     = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int OUT_W    = 32;
  localparam int COEF_W   = 24;
  localparam int COEF_FRAC = 20;
  localparam int IN_SHIFT  = 8;   // Q0 sample to Q8 output scale

  // Products and accumulator
  localparam int BX_W  = COEF_W + SAMPLE_W + 1;   // coef * zero-extended sample
  localparam int AY_W  = COEF_W + OUT_W;          // coef * output history
  localparam int ACC_W = AY_W + 2;                // four terms plus rounding
  localparam int Q_W   = ACC_W - COEF_FRAC;

  // Configuration port
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = COEF_W;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_B1 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B2 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A1 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A2 = CFG_IDX_W'(3);

  localparam logic signed [COEF_W-1:0] COEF_B1_RST = 24'sd7804;
  localparam logic signed [COEF_W-1:0] COEF_B2_RST = 24'sd7354;
  localparam logic signed [COEF_W-1:0] COEF_A1_RST = -24'sd1918894;
  localparam logic signed [COEF_W-1:0] COEF_A2_RST = 24'sd877658;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_set_t;

  typedef struct packed {
    coef_set_t coef;
    logic      busy;   // coefficient change not yet folded into partial sum
  } coef_status_t;

endpackage

>>> hdl/brsoi_if.sv
interface brsoi_in_if;
  logic                            valid;
  logic                            ready;
  logic [brsoi_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface brsoi_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [brsoi_pkg::OUT_W-1:0]  filtered;
  logic                                block_last;

  modport source (output valid, output filtered, output block_last, input ready);
  modport sink   (input valid, input filtered, input block_last, output ready);
endinterface

>>> hdl/block_restart_second_order_iir.sv
// A result appears on out_chan in the cycle after its sample is taken.
// Throughput: one sample per cycle unless out_chan stalls or a coefficient
//   write settles; the a1 multiply-add-saturate feedback is combinational.
// A coefficient write stalls in_chan in its own cycle and in the cycle after.
// Reset (rst_n low, synchronous): coefficients return to their defaults,
//   history and block position clear, the output register empties.
module block_restart_second_order_iir (
  input  logic                              clk,
  input  logic                              rst_n,
  brsoi_in_if.sink                          in_chan,
  brsoi_out_if.source                       out_chan,
  input  logic                              cfg_we,
  input  logic [brsoi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [brsoi_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  brsoi_pkg::coef_status_t            coef_status;
  logic                               accept;
  logic signed [brsoi_pkg::OUT_W-1:0] y;
  logic                               last;

  logic                               out_valid_r, out_valid_nxt;
  logic signed [brsoi_pkg::OUT_W-1:0] filtered_r;
  logic                               last_r;

  // Coefficient registers with write decode
  brsoi_coef_regs u_coef_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .status    (coef_status)
  );

  // Recursion core: history, block counter, partial sum and output math
  brsoi_recur u_recur (
    .clk    (clk),
    .rst_n  (rst_n),
    .coef   (coef_status.coef),
    .accept (accept),
    .sample (in_chan.sample),
    .y      (y),
    .last   (last)
  );

  // Take a new transaction whenever the output register is free or being
  // drained this cycle; hold off while a coefficient change settles.
  assign in_chan.ready = (!out_valid_r || out_chan.ready) && !coef_status.busy && !cfg_we;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;    // drop the result once it is taken
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload register: load on a transaction, otherwise hold
  always_ff @(posedge clk) begin
    if (accept) begin
      filtered_r <= y;
      last_r     <= last;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.filtered   = filtered_r;
  assign out_chan.block_last = last_r;

endmodule

>>> hdl/brsoi_coef_regs.sv
module brsoi_coef_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [brsoi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [brsoi_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output brsoi_pkg::coef_status_t           status
);

  brsoi_pkg::coef_set_t coef_r, coef_nxt;
  logic                 busy_r, busy_nxt;

  always_comb begin
    coef_nxt = coef_r;
    if (cfg_we) begin
      unique case (cfg_index)
        brsoi_pkg::REG_COEF_B1: coef_nxt.b1 = signed'(cfg_wdata);
        brsoi_pkg::REG_COEF_B2: coef_nxt.b2 = signed'(cfg_wdata);
        brsoi_pkg::REG_COEF_A1: coef_nxt.a1 = signed'(cfg_wdata);
        brsoi_pkg::REG_COEF_A2: coef_nxt.a2 = signed'(cfg_wdata);
        default: coef_nxt = coef_r;   // drop writes beyond the register list
      endcase
    end
    // hold off input after a write so the partial sum picks up the new weights
    busy_nxt = cfg_we;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.b1 <= brsoi_pkg::COEF_B1_RST;
      coef_r.b2 <= brsoi_pkg::COEF_B2_RST;
      coef_r.a1 <= brsoi_pkg::COEF_A1_RST;
      coef_r.a2 <= brsoi_pkg::COEF_A2_RST;
      busy_r    <= 1'b1;
    end else begin
      coef_r <= coef_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign status = {coef_r, busy_r};

endmodule

>>> hdl/brsoi_recur.sv
module brsoi_recur (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  brsoi_pkg::coef_set_t                 coef,
  input  logic                                 accept,
  input  logic [brsoi_pkg::SAMPLE_W-1:0]       sample,
  output logic signed [brsoi_pkg::OUT_W-1:0]   y,
  output logic                                 last
);

  localparam int ACC_W = brsoi_pkg::ACC_W;
  localparam logic signed [ACC_W-1:0] ROUND_HALF =
    ACC_W'(1) <<< (brsoi_pkg::COEF_FRAC - 1);

  logic [brsoi_pkg::SAMPLE_W-1:0]      x1_r, x1_nxt, x2_r, x2_nxt;
  logic signed [brsoi_pkg::OUT_W-1:0]  y1_r, y1_nxt, y2_r, y2_nxt;
  logic [brsoi_pkg::POS_W-1:0]         pos_r, pos_nxt;
  logic signed [ACC_W-1:0]             part_r, part_nxt;

  logic [brsoi_pkg::SAMPLE_W-1:0]      fx_a, fx_b;
  logic signed [brsoi_pkg::OUT_W-1:0]  fy;
  logic signed [brsoi_pkg::BX_W-1:0]   prod_b1, prod_b2;
  logic signed [brsoi_pkg::AY_W-1:0]   prod_a2, prod_a1;
  logic signed [ACC_W-1:0]             acc;
  logic signed [brsoi_pkg::Q_W-1:0]    q;
  logic                                ovf, pass;
  logic signed [brsoi_pkg::OUT_W-1:0]  y_rec;

  // Partial sum for the next item: everything but the a1 feedback term.
  // On a transaction it is built from the incoming sample and the current
  // history; otherwise it is rebuilt from the stored history.
  always_comb begin
    fx_a     = accept ? sample : x1_r;
    fx_b     = accept ? x1_r   : x2_r;
    fy       = accept ? y1_r   : y2_r;
    prod_b1  = coef.b1 * signed'({1'b0, fx_a});
    prod_b2  = coef.b2 * signed'({1'b0, fx_b});
    prod_a2  = coef.a2 * fy;
    part_nxt = (ACC_W'(prod_b1) <<< brsoi_pkg::IN_SHIFT)
             + (ACC_W'(prod_b2) <<< brsoi_pkg::IN_SHIFT)
             - ACC_W'(prod_a2);
  end

  // Output: close a1 loop, round half up, saturate; positions 0-1 bypass.
  always_comb begin
    prod_a1 = coef.a1 * y1_r;
    acc     = part_r - ACC_W'(prod_a1) + ROUND_HALF;
    q       = signed'(acc[ACC_W-1:brsoi_pkg::COEF_FRAC]);
    ovf     = (q[brsoi_pkg::Q_W-1:brsoi_pkg::OUT_W-1]
               != {(brsoi_pkg::Q_W-brsoi_pkg::OUT_W+1){q[brsoi_pkg::OUT_W-1]}});
    if (ovf) begin
      y_rec = q[brsoi_pkg::Q_W-1] ? brsoi_pkg::OUT_MIN : brsoi_pkg::OUT_MAX;
    end else begin
      y_rec = q[brsoi_pkg::OUT_W-1:0];
    end
    pass = (pos_r < brsoi_pkg::POS_W'(2));
    y    = pass ? signed'({{(brsoi_pkg::OUT_W-brsoi_pkg::SAMPLE_W-brsoi_pkg::IN_SHIFT){1'b0}},
                           sample, {brsoi_pkg::IN_SHIFT{1'b0}}})
                : y_rec;
    last = (pos_r == brsoi_pkg::POS_W'(brsoi_pkg::BLOCK_LEN - 1));
  end

  always_comb begin
    x1_nxt  = x1_r;
    x2_nxt  = x2_r;
    y1_nxt  = y1_r;
    y2_nxt  = y2_r;
    pos_nxt = pos_r;
    if (accept) begin
      x2_nxt  = x1_r;
      x1_nxt  = sample;
      y2_nxt  = y1_r;
      y1_nxt  = y;
      pos_nxt = last ? '0 : pos_r + brsoi_pkg::POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r  <= '0;
      x2_r  <= '0;
      y1_r  <= '0;
      y2_r  <= '0;
      pos_r <= '0;
    end else begin
      x1_r  <= x1_nxt;
      x2_r  <= x2_nxt;
      y1_r  <= y1_nxt;
      y2_r  <= y2_nxt;
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    part_r <= part_nxt;
  end

endmodule

>>> hdl/brsoi_checker.sv
module brsoi_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [brsoi_pkg::OUT_W-1:0] out_filtered,
  input logic                               out_block_last,
  input logic                               cfg_we
);

  // Every accepted sample shows a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("no result after accepted sample");

  // A coefficient write blocks input on the following cycle
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("input accepted right after coefficient write");

  // A stalled result stays offered
  a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_filtered) && $stable(out_block_last)))
    else $error("result payload changed while stalled");

endmodule

bind block_restart_second_order_iir brsoi_checker u_brsoi_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_filtered   (out_chan.filtered),
  .out_block_last (out_chan.block_last),
  .cfg_we         (cfg_we)
);
